// ----- design/htok_pkg.sv -----
// Shared types and constants for the HTTP request tokenizer.
package htok_pkg;

    localparam int BUFFER_BYTES_DEF = 512;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_QUEST = 8'h3f;
    localparam logic [7:0] CH_EQUAL = 8'h3d;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2b;

    // Token kinds
    localparam logic [2:0] KIND_METHOD = 3'd0;
    localparam logic [2:0] KIND_PATH   = 3'd1;
    localparam logic [2:0] KIND_QNAME  = 3'd2;
    localparam logic [2:0] KIND_QVAL   = 3'd3;
    localparam logic [2:0] KIND_HNAME  = 3'd4;
    localparam logic [2:0] KIND_HVAL   = 3'd5;
    localparam logic [2:0] KIND_NONE   = 3'd6;

    // Percent-escape progress
    localparam logic [1:0] DEC_IDLE = 2'd0;
    localparam logic [1:0] DEC_HIGH = 2'd1;
    localparam logic [1:0] DEC_LOW  = 2'd2;

    typedef enum logic [3:0] {
        PH_LEAD   = 4'd0,
        PH_METHOD = 4'd1,
        PH_GAP    = 4'd2,
        PH_PATH   = 4'd3,
        PH_QNAME  = 4'd4,
        PH_QVAL   = 4'd5,
        PH_REST   = 4'd6,
        PH_HNAME  = 4'd7,
        PH_HGAP   = 4'd8,
        PH_HVAL   = 4'd9
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] out_kind;
        logic       out_first;
        logic       out_done;
    } t_out_item;

    typedef struct packed {
        t_phase     phase;
        logic       line_dead;
        logic [1:0] dec_phase;
        logic [3:0] hex_high;
        logic       token_open;
        logic       line_empty;
        logic       msg_done;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        phase:      PH_LEAD,
        line_dead:  1'b0,
        dec_phase:  DEC_IDLE,
        hex_high:   4'd0,
        token_open: 1'b0,
        line_empty: 1'b1,
        msg_done:   1'b0
    };

endpackage

// ----- design/http_request_tokenizer.sv -----
// HTTP request tokenizer: one request byte per item in, zero or one tagged token byte out.
// An item waits in the input register until the result slot is free; its result is then
// registered. Throughput: one item per cycle unless the output stalls; the input register,
// per-byte decision logic and the result register form a two-register path, and an empty
// input register takes an item while a result waits. Synchronous active-low reset clears
// parse state, the decode register and both valid flags; the byte counter returns to zero.
module http_request_tokenizer
    import htok_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int CNT_W = $clog2(BUFFER_BYTES);

    // Decode enable for query values
    logic r_decode;

    // Input register
    logic     r_in_valid;
    t_in_item r_in_item;

    // Parse state, advanced once per processed item
    t_parse_state     r_state;
    t_parse_state     n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // Result register
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      step_valid;
    t_out_item step_item;
    logic      w_process;

    htok_step #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_step (
        .i_item  (r_in_item),
        .i_decode(r_decode),
        .i_state (r_state),
        .i_count (r_count),
        .o_state (n_state),
        .o_count (n_count),
        .o_valid (step_valid),
        .o_item  (step_item)
    );

    // Advance the held item when the result slot is empty or being drained this cycle
    assign w_process  = r_in_valid && (!r_out_valid || i_out_ready);
    // Take a new item whenever the input register is empty or moves on now
    assign o_in_ready = !r_in_valid || w_process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode    <= 1'b0;
            r_in_valid  <= 1'b0;
            r_state     <= PARSE_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_decode <= i_cfg_data;

            // Hold or refill the input register
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end

            // Commit the byte's effect on parse state and post its result, if any
            if (w_process) begin
                r_state     <= n_state;
                r_count     <= n_count;
                r_out_valid <= step_valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) r_in_item <= i_in_item;
        if (w_process) r_out_item <= step_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- design/htok_step.sv -----
// Per-byte tokenizer decision: next parse state and optional result item.
module htok_step
    import htok_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    localparam int CNT_W = $clog2(BUFFER_BYTES)
) (
    input  t_in_item     i_item,
    input  logic         i_decode,
    input  t_parse_state i_state,
    input  logic [CNT_W-1:0] i_count,
    output t_parse_state o_state,
    output logic [CNT_W-1:0] o_count,
    output logic         o_valid,
    output t_out_item    o_item
);

    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(BUFFER_BYTES - 1);

    function automatic logic [3:0] nibble_of(input logic [7:0] ch);
        logic [3:0] v;
        v = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) v = ch[3:0];
        else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
            v = ch[3:0] + 4'd9;
        return v;
    endfunction

    logic [7:0] c;
    logic       emit;
    logic       done;
    logic [2:0] kind;
    logic       first;

    always_comb begin
        o_state = i_state;
        o_count = i_count;
        c       = i_item.in_byte;
        emit    = 1'b0;
        done    = 1'b0;
        kind    = KIND_NONE;
        first   = 1'b0;

        if (i_state.msg_done) begin
            // Drop bytes until the last one, then restart
            if (i_item.in_last) begin
                o_state = PARSE_RESET;
                o_count = '0;
            end
        end else begin
            if (i_count >= COUNT_LIMIT || c == CH_NUL) begin
                done = 1'b1;
            end else begin
                o_count = i_count + CNT_W'(1);
                if (c == CH_LF) begin
                    if (i_state.phase >= PH_HNAME && i_state.line_empty) begin
                        done = 1'b1;
                    end else begin
                        o_state.phase      = PH_HNAME;
                        o_state.line_dead  = 1'b0;
                        o_state.line_empty = 1'b1;
                        o_state.token_open = 1'b0;
                    end
                end else if (i_state.line_dead) begin
                    // line silenced
                end else if (c < CH_SPACE || c >= CH_DEL) begin
                    o_state.line_dead = 1'b1;
                end else begin
                    o_state.line_empty = 1'b0;
                    case (i_state.phase)
                        PH_LEAD: begin
                            if (c != CH_SPACE) begin
                                emit = 1'b1; kind = KIND_METHOD;
                                o_state.phase = PH_METHOD;
                            end
                        end
                        PH_METHOD: begin
                            if (c == CH_SPACE) begin
                                o_state.token_open = 1'b0;
                                o_state.phase = PH_GAP;
                            end else begin
                                emit = 1'b1; kind = KIND_METHOD;
                            end
                        end
                        PH_GAP: begin
                            if (c == CH_QUEST) begin
                                o_state.phase = PH_QNAME;
                            end else if (c != CH_SPACE) begin
                                emit = 1'b1; kind = KIND_PATH;
                                o_state.phase = PH_PATH;
                            end
                        end
                        PH_PATH: begin
                            if (c == CH_SPACE) begin
                                o_state.token_open = 1'b0;
                                o_state.phase = PH_REST;
                            end else if (c == CH_QUEST) begin
                                o_state.token_open = 1'b0;
                                o_state.phase = PH_QNAME;
                            end else begin
                                emit = 1'b1; kind = KIND_PATH;
                            end
                        end
                        PH_QNAME: begin
                            if (c == CH_SPACE) begin
                                o_state.token_open = 1'b0;
                                o_state.phase = PH_REST;
                            end else if (c == CH_EQUAL) begin
                                o_state.token_open = 1'b0;
                                o_state.phase = PH_QVAL;
                            end else if (c == CH_AMP) begin
                                o_state.token_open = 1'b0;
                            end else begin
                                emit = 1'b1; kind = KIND_QNAME;
                            end
                        end
                        PH_QVAL: begin
                            if (c == CH_SPACE) begin
                                o_state.token_open = 1'b0;
                                o_state.phase = PH_REST;
                            end else if (c == CH_AMP) begin
                                o_state.token_open = 1'b0;
                                o_state.phase = PH_QNAME;
                            end else if (!i_decode) begin
                                o_state.dec_phase = DEC_IDLE;
                                emit = 1'b1; kind = KIND_QVAL;
                            end else if (i_state.dec_phase == DEC_HIGH) begin
                                o_state.hex_high  = nibble_of(c);
                                o_state.dec_phase = DEC_LOW;
                            end else if (i_state.dec_phase == DEC_LOW) begin
                                c = {i_state.hex_high, nibble_of(c)};
                                o_state.dec_phase = DEC_IDLE;
                                emit = 1'b1; kind = KIND_QVAL;
                            end else if (c == CH_PCT) begin
                                o_state.dec_phase = DEC_HIGH;
                            end else begin
                                if (c == CH_PLUS) c = CH_SPACE;
                                emit = 1'b1; kind = KIND_QVAL;
                            end
                        end
                        PH_HNAME: begin
                            if (c == CH_COLON) begin
                                o_state.token_open = 1'b0;
                                o_state.phase = PH_HGAP;
                            end else begin
                                emit = 1'b1; kind = KIND_HNAME;
                            end
                        end
                        PH_HGAP: begin
                            if (c != CH_SPACE) begin
                                emit = 1'b1; kind = KIND_HVAL;
                                o_state.phase = PH_HVAL;
                            end
                        end
                        PH_HVAL: begin
                            emit = 1'b1; kind = KIND_HVAL;
                        end
                        default: begin
                        end
                    endcase
                end
                // Drop any pending escape once outside a query value
                if (o_state.phase != PH_QVAL) begin
                    o_state.dec_phase = DEC_IDLE;
                    o_state.hex_high  = 4'd0;
                end
            end

            if (emit) begin
                first = ~o_state.token_open;
                o_state.token_open = 1'b1;
            end
            if (i_item.in_last) done = 1'b1;
            if (done) begin
                if (i_item.in_last) begin
                    o_state = PARSE_RESET;
                    o_count = '0;
                end else begin
                    o_state.msg_done = 1'b1;
                end
            end
        end

        o_valid          = emit | done;
        o_item.out_byte  = emit ? c : 8'd0;
        o_item.out_kind  = kind;
        o_item.out_first = first;
        o_item.out_done  = done;
    end

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for http_request_tokenizer with directed and random requests.
module testbench;
    import htok_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES     = 4;       // settle time after the last expected result
    localparam int DRAIN_LIMIT       = 20000;   // bound on waiting for late results
    localparam int LONG_STALL_CYCLES = 200;
    localparam int RANDOM_PHASE_ITEMS = 220;
    localparam int MAX_REPORTS       = 10;
    localparam longint TIMEOUT_NS    = 2_000_000;
    localparam string HEX_POOL       = "0123456789abcdefABCDEFgz%";

    // Clock, reset and block ports; every input is known from time zero
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_data  = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    // Tokenizer state mirrored on the testbench side
    t_parse_state tok;
    int unsigned  tok_count;
    bit           decode_on;

    // Expected token bytes, oldest first, and run statistics
    t_out_item    expected_tokens[$];
    bit [7:0]     msg_bytes[$];
    int           mismatch_count;
    int           items_sent;
    int           results_seen;
    int           messages_ended;
    int           long_stalls_wanted;
    int           long_stalls_served;
    int           ready_hold;
    bit           gaps_on;

    http_request_tokenizer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #(TIMEOUT_NS);
        $display("run timed out with %0d results outstanding", expected_tokens.size());
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        // Anything that is not a hex digit counts as zero
        if (c >= "0" && c <= "9") v = c - "0";
        else if (c >= "A" && c <= "F") v = c - "A" + 8'd10;
        else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
        else v = 8'd0;
        return v[3:0];
    endfunction

    function automatic void clear_tokenizer();
        tok       = PARSE_RESET;
        tok_count = 0;
    endfunction

    // Advance the mirrored state by one byte; return 1 when the byte yields a result
    function automatic bit predict_token(input t_in_item it, output t_out_item res);
        logic [7:0] c;
        logic [2:0] kind;
        bit         emit;
        bit         done;
        c    = it.in_byte;
        kind = KIND_NONE;
        emit = 1'b0;
        done = 1'b0;
        res  = '0;

        // After the end of a message, drop bytes until the last-marked one
        if (tok.msg_done) begin
            if (it.in_last) clear_tokenizer();
            return 1'b0;
        end

        if (tok_count >= BUFFER_BYTES_DEF - 1 || c == CH_NUL) begin
            done = 1'b1;
        end else begin
            tok_count++;
            if (c == CH_LF) begin
                // A blank header line ends the message; a blank request line does not
                if (tok.phase >= PH_HNAME && tok.line_empty) begin
                    done = 1'b1;
                end else begin
                    tok.phase      = PH_HNAME;
                    tok.line_dead  = 1'b0;
                    tok.line_empty = 1'b1;
                    tok.token_open = 1'b0;
                end
            end else if (!tok.line_dead) begin
                if (c < CH_SPACE || c >= CH_DEL) begin
                    tok.line_dead = 1'b1;
                end else begin
                    tok.line_empty = 1'b0;
                    case (tok.phase)
                        PH_LEAD: begin
                            if (c != CH_SPACE) begin
                                emit = 1'b1; kind = KIND_METHOD; tok.phase = PH_METHOD;
                            end
                        end
                        PH_METHOD: begin
                            if (c == CH_SPACE) begin
                                tok.token_open = 1'b0; tok.phase = PH_GAP;
                            end else begin
                                emit = 1'b1; kind = KIND_METHOD;
                            end
                        end
                        PH_GAP: begin
                            if (c == CH_QUEST) tok.phase = PH_QNAME;
                            else if (c != CH_SPACE) begin
                                emit = 1'b1; kind = KIND_PATH; tok.phase = PH_PATH;
                            end
                        end
                        PH_PATH: begin
                            if (c == CH_SPACE) begin
                                tok.token_open = 1'b0; tok.phase = PH_REST;
                            end else if (c == CH_QUEST) begin
                                tok.token_open = 1'b0; tok.phase = PH_QNAME;
                            end else begin
                                emit = 1'b1; kind = KIND_PATH;
                            end
                        end
                        PH_QNAME: begin
                            if (c == CH_SPACE) begin
                                tok.token_open = 1'b0; tok.phase = PH_REST;
                            end else if (c == CH_EQUAL) begin
                                tok.token_open = 1'b0; tok.phase = PH_QVAL;
                            end else if (c == CH_AMP) begin
                                tok.token_open = 1'b0;
                            end else begin
                                emit = 1'b1; kind = KIND_QNAME;
                            end
                        end
                        PH_QVAL: begin
                            if (c == CH_SPACE) begin
                                tok.token_open = 1'b0; tok.phase = PH_REST;
                            end else if (c == CH_AMP) begin
                                tok.token_open = 1'b0; tok.phase = PH_QNAME;
                            end else if (!decode_on) begin
                                tok.dec_phase = DEC_IDLE;
                                emit = 1'b1; kind = KIND_QVAL;
                            end else if (tok.dec_phase == DEC_HIGH) begin
                                tok.hex_high  = hex_value(c);
                                tok.dec_phase = DEC_LOW;
                            end else if (tok.dec_phase == DEC_LOW) begin
                                c = {tok.hex_high, hex_value(c)};
                                tok.dec_phase = DEC_IDLE;
                                emit = 1'b1; kind = KIND_QVAL;
                            end else if (c == CH_PCT) begin
                                tok.dec_phase = DEC_HIGH;
                            end else begin
                                if (c == CH_PLUS) c = CH_SPACE;
                                emit = 1'b1; kind = KIND_QVAL;
                            end
                        end
                        PH_HNAME: begin
                            if (c == CH_COLON) begin
                                tok.token_open = 1'b0; tok.phase = PH_HGAP;
                            end else begin
                                emit = 1'b1; kind = KIND_HNAME;
                            end
                        end
                        PH_HGAP: begin
                            if (c != CH_SPACE) begin
                                emit = 1'b1; kind = KIND_HVAL; tok.phase = PH_HVAL;
                            end
                        end
                        PH_HVAL: begin
                            emit = 1'b1; kind = KIND_HVAL;
                        end
                        default: ;
                    endcase
                end
            end
            // Leaving the value drops any escape still pending
            if (tok.phase != PH_QVAL) begin
                tok.dec_phase = DEC_IDLE;
                tok.hex_high  = 4'd0;
            end
        end

        if (emit) begin
            res.out_byte   = c;
            res.out_first  = !tok.token_open;
            tok.token_open = 1'b1;
        end
        if (it.in_last) done = 1'b1;
        if (done) begin
            if (it.in_last) clear_tokenizer();
            else tok.msg_done = 1'b1;
        end
        res.out_kind = kind;
        res.out_done = done;
        return emit || done;
    endfunction

    // ------------------------------------------------------------------
    // Driving and idling
    // ------------------------------------------------------------------

    // Mostly single-cycle gaps, some short runs, a few long ones
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 1;
        if (r < 90) return $urandom_range(2, 4);
        return $urandom_range(10, 40);
    endfunction

    // Offer one byte, hold it until accepted, then record what it should yield.
    // Call at a rising edge; returns at the edge that accepted the item.
    task automatic send_item(input logic [7:0] b, input logic last);
        t_in_item  it;
        t_out_item res;
        int        gap;
        it.in_byte = b;
        it.in_last = last;
        gap = (gaps_on && $urandom_range(0, 99) < 30) ? gap_length() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (predict_token(it, res)) expected_tokens.push_back(res);
    endtask

    task automatic send_text(input string s, input bit last_on_end);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(s[i], last_on_end && i == s.len() - 1);
    endtask

    // Send the assembled message, marking only its final byte as last
    task automatic send_message();
        int i;
        for (i = 0; i < msg_bytes.size(); i++)
            send_item(msg_bytes[i], i == msg_bytes.size() - 1);
    endtask

    // Stop offering, wait for every expected result, then let the pipeline settle
    task automatic drain_results();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (expected_tokens.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the decode register; only called while the block is idle
    task automatic write_decode(input bit value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        decode_on = value;
        i_cfg_we  <= 1'b0;
    endtask

    function automatic void push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
    endfunction

    function automatic void push_chars(input string pool, input int count);
        repeat (count) msg_bytes.push_back(pool[$urandom_range(0, pool.len() - 1)]);
    endfunction

    // Assemble a request: mostly well formed with random content, some noise
    function automatic void build_random_request();
        int pairs;
        int k;
        msg_bytes.delete();
        // Pure noise: every byte value, line endings and NULs included
        if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 24)) msg_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 3) == 0) push_chars(" ", $urandom_range(1, 2));
        push_chars("GETPOSHDU", $urandom_range(0, 5));
        push_chars(" ", $urandom_range(1, 2));
        if ($urandom_range(0, 5) != 0) push_text("/");
        push_chars("abz09/.-_~", $urandom_range(0, 6));
        if ($urandom_range(0, 3) != 0) begin
            push_text("?");
            pairs = $urandom_range(1, 3);
            for (k = 0; k < pairs; k++) begin
                if (k > 0) push_chars("&", $urandom_range(1, 2));
                push_chars("nmq9?_", $urandom_range(0, 4));
                if ($urandom_range(0, 4) != 0) begin
                    push_text("=");
                    repeat ($urandom_range(0, 4)) begin
                        if ($urandom_range(0, 2) == 0) begin
                            push_text("%");
                            push_chars(HEX_POOL, $urandom_range(0, 2));
                        end else begin
                            push_chars("av0Z+=?%", 1);
                        end
                    end
                end
            end
        end
        if ($urandom_range(0, 1) != 0) push_text(" HTTP/1.1");
        push_text("\n");
        repeat ($urandom_range(0, 3)) begin
            push_chars("HostAcept-", $urandom_range(0, 6));
            if ($urandom_range(0, 7) != 0) push_text(":");
            push_chars(" ", $urandom_range(0, 2));
            push_chars("abc 09:/=%", $urandom_range(0, 8));
            push_text("\n");
        end
        if ($urandom_range(0, 3) != 0) push_text("\n");
        // Break some requests with stray bytes
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 2))
                msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end
        // Trailing bytes after the end are dropped until the last one
        if ($urandom_range(0, 1) != 0) begin
            repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls plus requested long hold-offs
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            i_out_ready <= 1'b0;
        end else if (long_stalls_served < long_stalls_wanted) begin
            // Hold off long enough for the block to fill and stall its input
            long_stalls_served++;
            ready_hold = LONG_STALL_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 99) < 25) begin
            ready_hold = gap_length() - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_tokens.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: byte %h kind %0d first %b done %b",
                             o_out_item.out_byte, o_out_item.out_kind,
                             o_out_item.out_first, o_out_item.out_done);
            end else begin
                want = expected_tokens.pop_front();
                if (o_out_item.out_byte !== want.out_byte
                    || o_out_item.out_kind !== want.out_kind
                    || o_out_item.out_first !== want.out_first
                    || o_out_item.out_done !== want.out_done) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("result %0d: expected byte %h kind %0d first %b done %b",
                                 results_seen, want.out_byte, want.out_kind,
                                 want.out_first, want.out_done);
                        $display("    got byte %h kind %0d first %b done %b",
                                 o_out_item.out_byte, o_out_item.out_kind,
                                 o_out_item.out_first, o_out_item.out_done);
                    end
                end
                if (want.out_done) messages_ended++;
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Request line with decoding on: query pairs, repeated '?', empty names, escapes
    task automatic test_request_line_tokens();
        write_decode(1'b1);
        // Leading space, method, path, "a?" as one name, %4g -> '@', '+' -> space,
        // empty pair, empty name with "b=c" as value, escape cut short by a space
        send_text(" GET /p?a?=%4g+&&=b=c%2 X\n", 1'b0);
        // Header with an empty name, then a blank line that ends the message on last
        send_text(":v\n\n", 1'b1);
        // No path at all: the query opens straight after the method
        send_text("M ?x=%41\n\n", 1'b1);
    endtask

    // Line silencing, every way a message ends, and the byte extremes
    task automatic test_line_endings();
        send_text("H: v", 1'b0);
        send_item(8'h1f, 1'b0);          // control byte silences the rest of the line
        send_text("z\n", 1'b0);
        send_item(8'hff, 1'b0);          // non-ASCII as first byte makes the line blank
        send_text("\n", 1'b0);
        send_item(8'h00, 1'b0);          // ignored after the end
        send_item(8'h41, 1'b1);          // last byte restarts the parser
        send_text("\nA", 1'b0);          // blank request line does not end
        send_item(CH_NUL, 1'b0);         // NUL ends the message
        send_item(8'h80, 1'b1);
        send_item(CH_DEL, 1'b0);         // DEL silences the request line
        send_text("x\nAB", 1'b0);
        send_item(8'h7e, 1'b1);          // last byte is tokenized and ends the message
    endtask

    // Decoding off: escapes and '+' pass through raw
    task automatic test_raw_query_values();
        drain_results();
        write_decode(1'b0);
        send_text("P /x?k=%41+%\n\n", 1'b1);
    endtask

    // The byte at the buffer cap ends the message, with and without last on it
    task automatic test_buffer_cap();
        drain_results();
        write_decode(1'b1);
        msg_bytes.delete();
        push_text("GET /cap?q=%7e HTTP/1.1\n");
        while (msg_bytes.size() < BUFFER_BYTES_DEF + 6) push_text("X-Fill: abc=%41+z\n");
        send_message();
        // Exactly one buffer: last lands on the capped byte
        while (msg_bytes.size() > BUFFER_BYTES_DEF) void'(msg_bytes.pop_back());
        send_message();
    endtask

    // Receiver holds off while the sender keeps offering items back to back
    task automatic test_output_backpressure();
        drain_results();
        gaps_on = 1'b0;
        long_stalls_wanted++;
        repeat (3) begin
            build_random_request();
            send_message();
        end
        drain_results();
        gaps_on = 1'b1;
    endtask

    // Random requests in several decode and idling settings
    task automatic test_random_requests();
        int phase;
        int phase_start;
        for (phase = 0; phase < 4; phase++) begin
            drain_results();
            write_decode(phase == 1 || phase == 2);
            gaps_on = (phase != 2);
            phase_start = items_sent;
            while (items_sent - phase_start < RANDOM_PHASE_ITEMS) begin
                build_random_request();
                send_message();
            end
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        gaps_on   = 1'b1;
        decode_on = 1'b0;
        clear_tokenizer();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_request_line_tokens();
        test_line_endings();
        test_raw_query_values();
        test_buffer_cap();
        test_output_backpressure();
        test_random_requests();

        drain_results();
        if (expected_tokens.size() != 0) begin
            mismatch_count += expected_tokens.size();
            $display("%0d expected results never arrived", expected_tokens.size());
        end
        $display("covered %0d request bytes, %0d token results, %0d message ends",
                 items_sent, results_seen, messages_ended);
        $display("decode on and off, buffer cap, %0d long output stall(s), %0d mismatches",
                 long_stalls_served, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
